// ===== rtl/tpd_pkg.sv =====
// Shared types and constants for the timestamped period and duty capture block.
package tpd_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DEDUP      = 1'b1;

	localparam logic [31:0] LEVEL_MASK_RST = 32'h0002_0000;

	// duty quotient: 7 bits, saturated at 100
	localparam int unsigned DUTY_W   = 7;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
	localparam int unsigned NUM_W    = 40;   // 200 * high_total + period_total
	localparam int unsigned DEN_W    = 33;   // 2 * period_total

	// period divider: one quotient bit per step
	localparam int unsigned PQ_W     = 32;
	localparam int unsigned STEP_W   = $clog2(PQ_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PQ_W - 1);

	// front-to-back queue
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [31:0] level_mask;
		logic        dedup;
	} cfg_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] period_total;
		logic [31:0] high_total;
	} meas_t;

	typedef enum logic [1:0] {
		PH_UNKNOWN = 2'd0,
		PH_LOW     = 2'd1,
		PH_HIGH    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_RUN,
		BK_DONE
	} bk_state_t;

endpackage

// ===== rtl/tpd_fifo.sv =====
// Two-entry queue between the capture front end and the divider back end.
module tpd_fifo #(
	parameter int unsigned WIDTH = 72
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0]                 mem_q [tpd_pkg::FIFO_DEPTH];
	logic [tpd_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [tpd_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [tpd_pkg::FIFO_CNT_W-1:0]   count_q;

	assign full  = count_q == tpd_pkg::FIFO_CNT_W'(tpd_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tpd_front.sv =====
// Front end: takes samples, tracks edges and accumulates period and high time.
module tpd_front #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned RCW      = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpd_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          sample,
	input  logic [31:0]          timestamp,
	input  logic                 q_full,
	output logic                 push,
	output tpd_pkg::meas_t       meas,
	output logic [RCW-1:0]       rcnt
);

	localparam int unsigned SCW = $clog2(CAPACITY + 1);

	logic [SCW-1:0]    sample_count_q, sample_count_d;
	tpd_pkg::phase_t   phase_q, phase_d;
	logic [31:0]       rise_time_q, rise_time_d;
	logic [RCW-1:0]    rise_count_q, rise_count_d;
	logic [31:0]       period_total_q, period_total_d;
	logic [31:0]       high_time_q, high_time_d;
	logic [31:0]       high_total_q, high_total_d;
	logic [31:0]       prev_sample_q, prev_sample_d;
	logic              cap_full;
	logic              skip;
	logic              level;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// capture and edge tracking
	always_comb begin
		sample_count_d = sample_count_q;
		phase_d        = phase_q;
		rise_time_d    = rise_time_q;
		rise_count_d   = rise_count_q;
		period_total_d = period_total_q;
		high_time_d    = high_time_q;
		high_total_d   = high_total_q;
		prev_sample_d  = prev_sample_q;
		cap_full = sample_count_q == SCW'(CAPACITY);
		skip     = cfg.dedup && (sample_count_q != '0) && (sample == prev_sample_q);
		level    = |(sample & cfg.level_mask);
		if (!cap_full && !skip) begin
			prev_sample_d  = sample;
			sample_count_d = sample_count_q + 1'b1;
			if (level) begin
				if (phase_q == tpd_pkg::PH_LOW) begin
					// rising edge closes the previous period
					if (rise_count_q != '0) begin
						period_total_d = period_total_q + (rise_time_q - timestamp);
						high_total_d   = high_total_q + high_time_q;
						high_time_d    = '0;
					end
					rise_time_d  = timestamp;
					phase_d      = tpd_pkg::PH_HIGH;
					rise_count_d = rise_count_q + 1'b1;
				end
			end else begin
				if (phase_q == tpd_pkg::PH_HIGH) begin
					high_time_d = rise_time_q - timestamp;
				end
				phase_d = tpd_pkg::PH_LOW;
			end
		end
	end

	// snapshot handed to the back end
	assign meas.accepted     = !cap_full;
	assign meas.period_total = period_total_d;
	assign meas.high_total   = high_total_d;
	assign rcnt              = rise_count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			phase_q        <= tpd_pkg::PH_UNKNOWN;
			rise_time_q    <= '0;
			rise_count_q   <= '0;
			period_total_q <= '0;
			high_time_q    <= '0;
			high_total_q   <= '0;
		end else if (push) begin
			sample_count_q <= sample_count_d;
			phase_q        <= phase_d;
			rise_time_q    <= rise_time_d;
			rise_count_q   <= rise_count_d;
			period_total_q <= period_total_d;
			high_time_q    <= high_time_d;
			high_total_q   <= high_total_d;
		end
	end

	// last recorded sample, only compared once a sample has been recorded
	always_ff @(posedge clk) begin
		if (push) begin
			prev_sample_q <= prev_sample_d;
		end
	end

endmodule

// ===== rtl/tpd_back.sv =====
// Back end: iterative period and duty division with an output register.
module tpd_back #(
	parameter int unsigned RCW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  tpd_pkg::meas_t   q_meas,
	input  logic [RCW-1:0]   q_rcnt,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             accepted,
	output logic [31:0]      period_avg,
	output logic [6:0]       duty_percent
);

	tpd_pkg::bk_state_t state_q, state_d;

	logic                            out_load;
	logic                            run_step;
	logic                            out_valid_q;
	logic                            acc_q;
	logic                            pzero_q;
	logic [RCW-1:0]                  pdiv_q;
	logic [RCW-1:0]                  prem_q;
	logic [tpd_pkg::PQ_W-1:0]        pquo_q;
	logic                            dzero_q;
	logic                            sat_q;
	logic [tpd_pkg::NUM_W-1:0]       num_q;
	logic [tpd_pkg::DEN_W-1:0]       den_q;
	logic [tpd_pkg::NUM_W-1:0]       drem_q;
	logic [tpd_pkg::NUM_W-2:0]       dsh_q;
	logic [tpd_pkg::DUTY_W-1:0]      dq_q;
	logic [tpd_pkg::STEP_W-1:0]      step_q;
	logic [RCW:0]                    prem_sh;
	logic                            pbit;
	logic                            dbit;
	logic [tpd_pkg::NUM_W-1:0]       num_new;
	logic [tpd_pkg::DUTY_W-1:0]      duty_res;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpd_pkg::BK_IDLE:  if (!q_empty) state_d = tpd_pkg::BK_CHECK;
			tpd_pkg::BK_CHECK: state_d = tpd_pkg::BK_RUN;
			tpd_pkg::BK_RUN:   if (step_q == tpd_pkg::STEP_LAST) state_d = tpd_pkg::BK_DONE;
			tpd_pkg::BK_DONE:  if (!out_valid_q || out_ready) state_d = tpd_pkg::BK_IDLE;
			default:           state_d = tpd_pkg::BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		run_step = 1'b0;
		unique case (state_q)
			tpd_pkg::BK_IDLE:  pop      = !q_empty;
			tpd_pkg::BK_CHECK: ;
			tpd_pkg::BK_RUN:   run_step = 1'b1;
			tpd_pkg::BK_DONE:  out_load = !out_valid_q || out_ready;
			default:           ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpd_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// restoring step, period: one quotient bit
	assign prem_sh = {prem_q, pquo_q[tpd_pkg::PQ_W-1]};
	assign pbit    = prem_sh >= {1'b0, pdiv_q};
	// restoring step, duty: one quotient bit against the shifted divisor
	assign dbit    = drem_q >= {1'b0, dsh_q};
	// 200 * high_total + period_total by shifts and adds
	assign num_new = (tpd_pkg::NUM_W'(q_meas.high_total) << 7)
		+ (tpd_pkg::NUM_W'(q_meas.high_total) << 6)
		+ (tpd_pkg::NUM_W'(q_meas.high_total) << 3)
		+ tpd_pkg::NUM_W'(q_meas.period_total);

	// divider datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q   <= q_meas.accepted;
			pzero_q <= (q_rcnt <= RCW'(1));
			pdiv_q  <= q_rcnt - 1'b1;
			prem_q  <= '0;
			pquo_q  <= q_meas.period_total;
			dzero_q <= q_meas.period_total == '0;
			num_q   <= num_new;
			den_q   <= {q_meas.period_total, 1'b0};
		end
		if (state_q == tpd_pkg::BK_CHECK) begin
			sat_q  <= num_q >= {den_q, 7'b0};
			drem_q <= num_q;
			dsh_q  <= {den_q, 6'b0};
			dq_q   <= '0;
			step_q <= '0;
		end
		if (run_step) begin
			step_q <= step_q + 1'b1;
			if (pbit) begin
				prem_q <= RCW'(prem_sh - {1'b0, pdiv_q});
			end else begin
				prem_q <= prem_sh[RCW-1:0];
			end
			pquo_q <= {pquo_q[tpd_pkg::PQ_W-2:0], pbit};
			if (step_q < tpd_pkg::STEP_W'(tpd_pkg::DUTY_W)) begin
				if (dbit) begin
					drem_q <= drem_q - {1'b0, dsh_q};
				end
				dq_q  <= {dq_q[tpd_pkg::DUTY_W-2:0], dbit};
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	// saturate and select the duty result
	always_comb begin
		if (dzero_q) begin
			duty_res = '0;
		end else if (sat_q || (dq_q > tpd_pkg::DUTY_MAX)) begin
			duty_res = tpd_pkg::DUTY_MAX;
		end else begin
			duty_res = dq_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted     <= acc_q;
			period_avg   <= pzero_q ? '0 : pquo_q;
			duty_percent <= duty_res;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/timestamped_capture_period_duty.sv =====
// Top level: configuration registers, front end, queue and divider back end.
// Each item is queued, popped, passed through the check state and the 32-step
// bit-serial period divider, then loaded into the output register once it is free.
// The two-entry queue lets up to two further items be taken while the divider works.
// Reset: arst_n clears the front-end counters and accumulators, the queue, the back-end
// state and output valid at once; level_mask resets to 0x00020000 and dedup to 0.
module timestamped_capture_period_duty #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [31:0]                       sample,
	input  logic [31:0]                       timestamp,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              accepted,
	output logic [31:0]                       period_avg,
	output logic [6:0]                        duty_percent
);

	localparam int unsigned RCW = $clog2(CAPACITY / 2 + 1);
	localparam int unsigned QW  = $bits(tpd_pkg::meas_t) + RCW;

	tpd_pkg::cfg_t   cfg_q;
	tpd_pkg::meas_t  f_meas;
	tpd_pkg::meas_t  q_meas;
	logic [RCW-1:0]  f_rcnt;
	logic [RCW-1:0]  q_rcnt;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_mask <= tpd_pkg::LEVEL_MASK_RST;
			cfg_q.dedup      <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tpd_pkg::REG_LEVEL_MASK: cfg_q.level_mask <= cfg_data;
				tpd_pkg::REG_DEDUP:      cfg_q.dedup      <= cfg_data[0];
				default:                 ;
			endcase
		end
	end

	tpd_front #(
		.CAPACITY (CAPACITY),
		.RCW      (RCW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.timestamp (timestamp),
		.q_full    (q_full),
		.push      (push),
		.meas      (f_meas),
		.rcnt      (f_rcnt)
	);

	tpd_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_meas, f_rcnt}),
		.pop    (pop),
		.rdata  ({q_meas, q_rcnt}),
		.full   (q_full),
		.empty  (q_empty)
	);

	tpd_back #(
		.RCW (RCW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_meas       (q_meas),
		.q_rcnt       (q_rcnt),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.period_avg   (period_avg),
		.duty_percent (duty_percent)
	);

	// duty result never exceeds the saturation limit
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_percent <= tpd_pkg::DUTY_MAX))
		else $error("duty_percent above saturation limit");

	// mask write lands in the register
	a_mask_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wen && (cfg_index == tpd_pkg::REG_LEVEL_MASK))
		|=> (cfg_q.level_mask == $past(cfg_data)))
		else $error("level_mask write lost");

	// queue is never popped while empty
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule
